>>> src/brr_pkg.sv
`default_nettype none
package brr_pkg;

  // input word kinds
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_NEAREST  = 2'd1;
  localparam logic [1:0] KIND_BILINEAR = 2'd2;

  // field widths
  localparam int KIND_W   = 2;
  localparam int COL_W    = 6;
  localparam int ROW_W    = 6;
  localparam int PIX_W    = 32;
  localparam int COORD_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int REGION_W = 7;

  // store geometry
  localparam int REGION_MAX_WIDTH  = 64;
  localparam int REGION_MAX_HEIGHT = 64;
  localparam int CANVAS_MAX        = 4096;
  localparam int STORE_DEPTH       = REGION_MAX_WIDTH * REGION_MAX_HEIGHT;
  localparam int ADDR_W            = COL_W + ROW_W;

  // coordinate divider
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = 2 * SIZE_W;
  localparam int DEN_W      = SIZE_W + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (NUM_W + FRAC_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W      = DIV_STAGES * DIV_STEPS;
  localparam int INT_W      = DIV_W - FRAC_W;

  // register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_TGT_W  = 3'd2;
  localparam logic [2:0] REG_TGT_H  = 3'd3;
  localparam logic [2:0] REG_LEFT   = 3'd4;
  localparam logic [2:0] REG_TOP    = 3'd5;
  localparam logic [2:0] REG_RGN_W  = 3'd6;
  localparam logic [2:0] REG_RGN_H  = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [PIX_W-1:0]  pixel;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic [COORD_W-1:0] near;
    logic [7:0]         w;
  } axis_t;

  function automatic logic [SIZE_W-1:0] clamp_canvas(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(CANVAS_MAX)) r = SIZE_W'(CANVAS_MAX);
    else r = v;
    return r;
  endfunction

  function automatic logic [REGION_W-1:0] clamp_region(input logic [REGION_W-1:0] v,
                                                        input logic [REGION_W-1:0] m);
    logic [REGION_W-1:0] r;
    if (v == '0) r = REGION_W'(1);
    else if (v > m) r = m;
    else r = v;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_hi(input logic [INT_W:0] v,
                                                  input logic [COORD_W-1:0] m);
    logic [COORD_W-1:0] r;
    if (v > {{(INT_W+1-COORD_W){1'b0}}, m}) r = m;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  // Split a 28.16 quotient into taps, nearest pixel and weight; m is size-1.
  function automatic axis_t axis_taps(input logic [DIV_W-1:0] q,
                                      input logic [COORD_W-1:0] m);
    axis_t             a;
    logic [INT_W:0]    qi;
    logic [INT_W:0]    lo_raw;
    logic [INT_W:0]    hi_raw;
    logic              neg;
    qi     = {1'b0, q[DIV_W-1:FRAC_W]};
    neg    = (qi == '0) && !q[FRAC_W-1];
    lo_raw = q[FRAC_W-1] ? qi : qi - (INT_W+1)'(1);
    hi_raw = q[FRAC_W-1] ? qi + (INT_W+1)'(1) : qi;
    a.lo   = neg ? '0 : clamp_hi(lo_raw, m);
    a.hi   = clamp_hi(hi_raw, m);
    a.near = clamp_hi(qi, m);
    a.w    = {~q[FRAC_W-1], q[FRAC_W-2:FRAC_W-8]};
    return a;
  endfunction

  // (a*(256-w) + b*w) >> 8
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] w);
    logic [16:0] acc;
    logic [8:0]  wc;
    wc  = 9'd256 - {1'b0, w};
    acc = {9'b0, a} * {8'b0, wc} + {9'b0, b} * {9'b0, w};
    return acc[15:8];
  endfunction

endpackage
`default_nettype wire

>>> src/brr_ram.sv
`default_nettype none
module brr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, hold while disabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> src/brr_div.sv
`default_nettype none
module brr_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [brr_pkg::NUM_W-1:0]   num_i,
  input  wire logic [brr_pkg::DEN_W-1:0]   den_i,
  output logic      [brr_pkg::DIV_W-1:0]   quo_o
);
  import brr_pkg::*;

  logic [DEN_W-1:0] rem_q  [DIV_STAGES];
  logic [DIV_W-1:0] work_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q  [DIV_STAGES];

  // restoring division of num*2^16 by den, a few quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DIV_W-1:0] work_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_d;
    logic [DIV_W-1:0] work_d;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = {{(DIV_W-NUM_W-FRAC_W){1'b0}}, num_i, {FRAC_W{1'b0}}};
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign work_in = work_q[g-1];
      assign den_in  = den_q[g-1];
    end

    always_comb begin
      logic [DEN_W:0]   sh;
      logic [DEN_W-1:0] rem;
      logic [DIV_W-1:0] work;
      rem  = rem_in;
      work = work_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        sh   = {rem, work[DIV_W-1]};
        work = {work[DIV_W-2:0], 1'b0};
        if (sh >= {1'b0, den_in}) begin
          sh      = sh - {1'b0, den_in};
          work[0] = 1'b1;
        end
        rem = sh[DEN_W-1:0];
      end
      rem_d  = rem;
      work_d = work;
    end

    // advance stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        work_q[g] <= work_d;
        den_q[g]  <= den_in;
      end
    end
  end

  assign quo_o = work_q[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> src/bilinear_region_resampler_core.sv
`default_nettype none
// Channel  Direction  Handshake                 Words
// in       input      in_valid_i / in_ready_o   kind, load column/row/pixel, target x/y
// out      output     out_valid_o / out_ready_i pixel_out
// cfg      input      APB psel/penable/pwrite   eight size and region registers
//
// One word is taken every cycle unless the output stalls; samples pass through the
// pipelined coordinate divider.
// Loads travel the same pipe and write the store at the read stage, so order holds.
// Reset clears valid bits and configuration registers; the pixel store is not cleared.
// A stall at the output freezes every stage; nothing is dropped or repeated.
module bilinear_region_resampler_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [brr_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [brr_pkg::COL_W-1:0]     load_column_i,
  input  wire logic [brr_pkg::ROW_W-1:0]     load_row_i,
  input  wire logic [brr_pkg::PIX_W-1:0]     load_pixel_i,
  input  wire logic [brr_pkg::COORD_W-1:0]   target_x_i,
  input  wire logic [brr_pkg::COORD_W-1:0]   target_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [brr_pkg::PIX_W-1:0]     pixel_out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [brr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [brr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [brr_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import brr_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]   src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic [COORD_W-1:0]  left_q, top_q;
  logic [REGION_W-1:0] rgn_w_q, rgn_h_q;
  logic [2:0]          reg_idx;
  logic                cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SIZE_W'(1);
      src_h_q <= SIZE_W'(1);
      tgt_w_q <= SIZE_W'(1);
      tgt_h_q <= SIZE_W'(1);
      left_q  <= '0;
      top_q   <= '0;
      rgn_w_q <= REGION_W'(1);
      rgn_h_q <= REGION_W'(1);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SRC_W: src_w_q <= pwdata[SIZE_W-1:0];
        REG_SRC_H: src_h_q <= pwdata[SIZE_W-1:0];
        REG_TGT_W: tgt_w_q <= pwdata[SIZE_W-1:0];
        REG_TGT_H: tgt_h_q <= pwdata[SIZE_W-1:0];
        REG_LEFT:  left_q  <= pwdata[COORD_W-1:0];
        REG_TOP:   top_q   <= pwdata[COORD_W-1:0];
        REG_RGN_W: rgn_w_q <= pwdata[REGION_W-1:0];
        REG_RGN_H: rgn_h_q <= pwdata[REGION_W-1:0];
        default:   ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_SRC_W: prdata = PDATA_W'(src_w_q);
      REG_SRC_H: prdata = PDATA_W'(src_h_q);
      REG_TGT_W: prdata = PDATA_W'(tgt_w_q);
      REG_TGT_H: prdata = PDATA_W'(tgt_h_q);
      REG_LEFT:  prdata = PDATA_W'(left_q);
      REG_TOP:   prdata = PDATA_W'(top_q);
      REG_RGN_W: prdata = PDATA_W'(rgn_w_q);
      REG_RGN_H: prdata = PDATA_W'(rgn_h_q);
      default:   prdata = '0;
    endcase
  end

  // clamped sizes
  logic [SIZE_W-1:0]   sw, sh, tw, th;
  logic [COORD_W-1:0]  sw_m1, sh_m1;
  logic [REGION_W-1:0] rw, rh;

  assign sw    = clamp_canvas(src_w_q);
  assign sh    = clamp_canvas(src_h_q);
  assign tw    = clamp_canvas(tgt_w_q);
  assign th    = clamp_canvas(tgt_h_q);
  assign sw_m1 = COORD_W'(sw - SIZE_W'(1));
  assign sh_m1 = COORD_W'(sh - SIZE_W'(1));
  assign rw    = clamp_region(rgn_w_q, REGION_W'(REGION_MAX_WIDTH));
  assign rh    = clamp_region(rgn_h_q, REGION_W'(REGION_MAX_HEIGHT));

  // global advance
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage a: register word, form numerators (2t+1)*S
  logic             va_q;
  item_t            item_a_q;
  logic [NUM_W-1:0] nx_a_q, ny_a_q;
  logic [NUM_W-1:0] nx_a_d, ny_a_d;

  assign nx_a_d = {{(NUM_W-SIZE_W){1'b0}}, target_x_i, 1'b1} * {{(NUM_W-SIZE_W){1'b0}}, sw};
  assign ny_a_d = {{(NUM_W-SIZE_W){1'b0}}, target_y_i, 1'b1} * {{(NUM_W-SIZE_W){1'b0}}, sh};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_a_q <= '{kind: kind_i, col: load_column_i, row: load_row_i, pixel: load_pixel_i};
      nx_a_q   <= nx_a_d;
      ny_a_q   <= ny_a_d;
    end
  end

  // divider stages, side data rides alongside
  logic [DIV_W-1:0] qx, qy;

  brr_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nx_a_q),
    .den_i ({tw, 1'b0}),
    .quo_o (qx)
  );

  brr_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_a_q),
    .den_i ({th, 1'b0}),
    .quo_o (qy)
  );

  logic  vs_q    [DIV_STAGES];
  item_t item_s_q[DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STAGES; i++) vs_q[i] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= va_q;
      for (int i = 1; i < DIV_STAGES; i++) vs_q[i] <= vs_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_s_q[0] <= item_a_q;
      for (int i = 1; i < DIV_STAGES; i++) item_s_q[i] <= item_s_q[i-1];
    end
  end

  // stage b: taps and weights; nearest uses one tap with zero weights
  axis_t              ax, ay;
  logic               vb_q;
  item_t              item_b_q;
  logic [COORD_W-1:0] xl_q, xr_q, yt_q, yb_q;
  logic [7:0]         h_b_q, v_b_q;
  logic               near_s;

  assign ax     = axis_taps(qx, sw_m1);
  assign ay     = axis_taps(qy, sh_m1);
  assign near_s = item_s_q[DIV_STAGES-1].kind == KIND_NEAREST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= vs_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_b_q <= item_s_q[DIV_STAGES-1];
      xl_q     <= near_s ? ax.near : ax.lo;
      xr_q     <= near_s ? ax.near : ax.hi;
      yt_q     <= near_s ? ay.near : ay.lo;
      yb_q     <= near_s ? ay.near : ay.hi;
      h_b_q    <= near_s ? 8'd0 : ax.w;
      v_b_q    <= near_s ? 8'd0 : ay.w;
    end
  end

  // stage c: region test and store addresses (tl, tr, bl, br)
  logic              vc_q;
  item_t             item_c_q;
  logic [3:0]        ins_c_q;
  logic [ADDR_W-1:0] addr_c_q[4];
  logic [7:0]        h_c_q, v_c_q;
  logic [3:0]        ins_d;
  logic [ADDR_W-1:0] addr_d[4];

  always_comb begin
    logic [COORD_W-1:0] tx, ty, dx, dy;
    for (int k = 0; k < 4; k++) begin
      tx = k[0] ? xr_q : xl_q;
      ty = k[1] ? yb_q : yt_q;
      dx = tx - left_q;
      dy = ty - top_q;
      ins_d[k]  = (tx >= left_q) && (dx < COORD_W'(rw)) &&
                  (ty >= top_q) && (dy < COORD_W'(rh));
      addr_d[k] = {dy[ROW_W-1:0], dx[COL_W-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_c_q <= item_b_q;
      ins_c_q  <= ins_d;
      addr_c_q <= addr_d;
      h_c_q    <= h_b_q;
      v_c_q    <= v_b_q;
    end
  end

  // store copies: loads write all four, each copy serves one tap
  logic             st_we;
  logic [PIX_W-1:0] rdata[4];

  assign st_we = en && vc_q && (item_c_q.kind == KIND_LOAD);

  for (genvar t = 0; t < 4; t++) begin : g_store
    brr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (st_we),
      .waddr_i ({item_c_q.row, item_c_q.col}),
      .wdata_i (item_c_q.pixel),
      .re_i    (en),
      .raddr_i (addr_c_q[t]),
      .rdata_o (rdata[t])
    );
  end

  // stage d: read data arrives
  logic              vd_q;
  logic [KIND_W-1:0] kind_d_q;
  logic [3:0]        ins_d_q;
  logic [7:0]        h_d_q, v_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_d_q <= item_c_q.kind;
      ins_d_q  <= ins_c_q;
      h_d_q    <= h_c_q;
      v_d_q    <= v_c_q;
    end
  end

  // stage e: zero taps outside the region, blend vertically
  logic [PIX_W-1:0]  tap[4];
  logic              ve_q;
  logic [KIND_W-1:0] kind_e_q;
  logic [7:0]        h_e_q;
  logic [7:0]        lft_q[4], rgt_q[4];
  logic [7:0]        lft_d[4], rgt_d[4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tap[k] = ins_d_q[k] ? rdata[k] : '0;
    end
    for (int c = 0; c < 4; c++) begin
      lft_d[c] = lerp8(tap[0][8*c +: 8], tap[2][8*c +: 8], v_d_q);
      rgt_d[c] = lerp8(tap[1][8*c +: 8], tap[3][8*c +: 8], v_d_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_e_q <= kind_d_q;
      h_e_q    <= h_d_q;
      lft_q    <= lft_d;
      rgt_q    <= rgt_d;
    end
  end

  // output register: blend horizontally, drop loads and unused kinds
  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_q, pixel_d;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pixel_d[8*c +: 8] = lerp8(lft_q[c], rgt_q[c], h_e_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ve_q && (kind_e_q == KIND_NEAREST || kind_e_q == KIND_BILINEAR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;

  // checks
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vd_q) && $stable(ve_q) && $stable(vb_q))
    else $error("pipeline moved during stall");

  a_near_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && item_b_q.kind == KIND_NEAREST |-> h_b_q == 8'd0 && v_b_q == 8'd0 &&
      xl_q == xr_q && yt_q == yb_q)
    else $error("nearest sample has blend weights");

  a_tap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (xr_q == xl_q || xr_q == xl_q + COORD_W'(1)) &&
      (yb_q == yt_q || yb_q == yt_q + COORD_W'(1)))
    else $error("tap pair not adjacent");

  a_no_write_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |=> !(ve_q == 1'b0 && vd_q == 1'b1 && kind_d_q != KIND_LOAD))
    else $error("store write tagged as sample");

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import brr_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KIND_W-1:0]    kind_i = KIND_LOAD;
  logic [COL_W-1:0]     load_column_i = '0;
  logic [ROW_W-1:0]     load_row_i = '0;
  logic [PIX_W-1:0]     load_pixel_i = '0;
  logic [COORD_W-1:0]   target_x_i = '0;
  logic [COORD_W-1:0]   target_y_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;

  bilinear_region_resampler_core i_dut (.*);

  always #1 clk_i = ~clk_i;

  // shadow of the register file and the pixel store
  int unsigned      src_w, src_h, tgt_w, tgt_h, rgn_left, rgn_top, rgn_w, rgn_h;
  logic [PIX_W-1:0] pixel_mem [STORE_DEPTH];
  bit               pixel_written [STORE_DEPTH];
  logic [PIX_W-1:0] expected_pixels [$];
  int               mismatches = 0;
  bit               hold_req = 1'b0;
  bit               no_idle = 1'b0;

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint size_of(int unsigned v, int unsigned hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  function automatic longint fix_floor(longint c);
    if (c >= 0) return c / 65536;
    return -((-c + 65535) / 65536);
  endfunction

  // taps of a sample: nearest uses entry 0 only; also return blend weights
  function automatic void sample_taps(input logic [1:0] kind, input int unsigned tx,
                                      input int unsigned ty, output longint px[4],
                                      output longint py[4], output int unsigned wh,
                                      output int unsigned wv);
    longint sw, sh, tw, th, fx, fy, bx, by;
    sw = size_of(src_w, CANVAS_MAX);
    sh = size_of(src_h, CANVAS_MAX);
    tw = size_of(tgt_w, CANVAS_MAX);
    th = size_of(tgt_h, CANVAS_MAX);
    wh = 0;
    wv = 0;
    if (kind == KIND_NEAREST) begin
      px[0] = clamp_l(((2 * longint'(tx) + 1) * sw) / (2 * tw), 0, sw - 1);
      py[0] = clamp_l(((2 * longint'(ty) + 1) * sh) / (2 * th), 0, sh - 1);
      for (int i = 1; i < 4; i++) begin
        px[i] = px[0];
        py[i] = py[0];
      end
    end else begin
      fx = ((2 * longint'(tx) + 1) * sw * 65536) / (2 * tw) - 32768;
      fy = ((2 * longint'(ty) + 1) * sh * 65536) / (2 * th) - 32768;
      bx = fix_floor(fx);
      by = fix_floor(fy);
      px[0] = clamp_l(bx, 0, sw - 1);     py[0] = clamp_l(by, 0, sh - 1);
      px[1] = clamp_l(bx + 1, 0, sw - 1); py[1] = py[0];
      px[2] = px[0];                      py[2] = clamp_l(by + 1, 0, sh - 1);
      px[3] = px[1];                      py[3] = py[2];
      wh = int'((fx - bx * 65536) >> 8);
      wv = int'((fy - by * 65536) >> 8);
    end
  endfunction

  // store index of a canvas tap, or -1 outside the loaded region
  function automatic int region_index(longint x, longint y);
    longint rw, rh;
    rw = size_of(rgn_w, REGION_MAX_WIDTH);
    rh = size_of(rgn_h, REGION_MAX_HEIGHT);
    if (x < rgn_left || x >= rgn_left + rw || y < rgn_top || y >= rgn_top + rh)
      return -1;
    return int'((y - rgn_top) * REGION_MAX_WIDTH + (x - rgn_left));
  endfunction

  function automatic bit taps_loaded(logic [1:0] kind, int unsigned tx, int unsigned ty);
    longint px[4], py[4];
    int unsigned wh, wv;
    int idx;
    sample_taps(kind, tx, ty, px, py, wh, wv);
    for (int i = 0; i < 4; i++) begin
      idx = region_index(px[i], py[i]);
      if (idx >= 0 && !pixel_written[idx]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] resample_pixel(logic [1:0] kind, int unsigned tx,
                                                     int unsigned ty);
    longint px[4], py[4];
    int unsigned wh, wv, a, b, c, d, lft, rgt;
    int idx;
    logic [PIX_W-1:0] t [4];
    logic [PIX_W-1:0] res;
    sample_taps(kind, tx, ty, px, py, wh, wv);
    for (int i = 0; i < 4; i++) begin
      idx = region_index(px[i], py[i]);
      t[i] = idx < 0 ? '0 : pixel_mem[idx];
    end
    if (kind == KIND_NEAREST) return t[0];
    res = '0;
    for (int s = 0; s < 32; s += 8) begin
      a = (t[0] >> s) & 255; b = (t[1] >> s) & 255;
      c = (t[2] >> s) & 255; d = (t[3] >> s) & 255;
      lft = (a * (256 - wv) + c * wv) >> 8;
      rgt = (b * (256 - wv) + d * wv) >> 8;
      res[s +: 8] = 8'((lft * (256 - wh) + rgt * wh) >> 8);
    end
    return res;
  endfunction

  // pick a gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one input word and update the shadow model
  task automatic send_word(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                           logic [31:0] pix, logic [11:0] tx, logic [11:0] ty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    load_column_i <= col;
    load_row_i    <= row;
    load_pixel_i  <= pix;
    target_x_i    <= tx;
    target_y_i    <= ty;
    if (kind == KIND_LOAD) begin
      pixel_mem[row * REGION_MAX_WIDTH + col] = pix;
      pixel_written[row * REGION_MAX_WIDTH + col] = 1'b1;
    end else if (kind != KIND_UNUSED) begin
      expected_pixels.push_back(resample_pixel(kind, tx, ty));
    end
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
  endtask

  task automatic end_words();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for the pipe to drain before touching registers
  task automatic wait_idle();
    end_words();
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SRC_W: src_w    = val & 13'h1fff;
      REG_SRC_H: src_h    = val & 13'h1fff;
      REG_TGT_W: tgt_w    = val & 13'h1fff;
      REG_TGT_H: tgt_h    = val & 13'h1fff;
      REG_LEFT:  rgn_left = val & 12'hfff;
      REG_TOP:   rgn_top  = val & 12'hfff;
      REG_RGN_W: rgn_w    = val & 7'h7f;
      default:   rgn_h    = val & 7'h7f;
    endcase
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned l, int unsigned t,
                              int unsigned rw, int unsigned rh);
    wait_idle();
    reg_write(REG_SRC_W, sw);
    reg_write(REG_SRC_H, sh);
    reg_write(REG_TGT_W, tw);
    reg_write(REG_TGT_H, th);
    reg_write(REG_LEFT, l);
    reg_write(REG_TOP, t);
    reg_write(REG_RGN_W, rw);
    reg_write(REG_RGN_H, rh);
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // fill every entry of the current region
  task automatic fill_region();
    int unsigned rw, rh;
    rw = size_of(rgn_w, REGION_MAX_WIDTH);
    rh = size_of(rgn_h, REGION_MAX_HEIGHT);
    for (int r = 0; r < rh; r++)
      for (int c = 0; c < rw; c++)
        send_word(KIND_LOAD, 6'(c), 6'(r), rand_pixel(), 12'($urandom), 12'($urandom));
  endtask

  // target coordinate that lands near the loaded region
  function automatic int unsigned aim(int unsigned lo, int unsigned span, int unsigned s,
                                      int unsigned t);
    longint sc, tc, v;
    sc = size_of(s, CANVAS_MAX);
    tc = size_of(t, CANVAS_MAX);
    v = ((longint'(lo) + $urandom_range(0, span + 1)) * tc) / sc
        + $urandom_range(0, 2) - 1;
    return int'(clamp_l(v, 0, 4095));
  endfunction

  task automatic random_sample();
    logic [1:0] kind;
    int unsigned tx, ty;
    kind = $urandom_range(0, 1) ? KIND_BILINEAR : KIND_NEAREST;
    if ($urandom_range(0, 9) < 7) begin
      tx = aim(rgn_left, size_of(rgn_w, REGION_MAX_WIDTH), src_w, tgt_w);
      ty = aim(rgn_top, size_of(rgn_h, REGION_MAX_HEIGHT), src_h, tgt_h);
    end else begin
      tx = $urandom_range(0, 4095);
      ty = $urandom_range(0, 4095);
    end
    if (taps_loaded(kind, tx, ty))
      send_word(kind, 6'($urandom), 6'($urandom), $urandom, 12'(tx), 12'(ty));
  endtask

  task automatic test_defaults();
    send_word(KIND_LOAD, 6'd0, 6'd0, 32'hffff_ffff, 12'd0, 12'd0);
    send_word(KIND_NEAREST, 6'd63, 6'd63, 32'h0, 12'd0, 12'd0);
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'd0, 12'd0);
    send_word(KIND_UNUSED, 6'd5, 6'd7, 32'h1234_5678, 12'd1, 12'd1);
    send_word(KIND_NEAREST, 6'd0, 6'd0, 32'h0, 12'hfff, 12'hfff);
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'hfff, 12'hfff);
  endtask

  task automatic test_upscale_corners();
    set_geometry(8, 8, 16, 16, 0, 0, 8, 8);
    fill_region();
    send_word(KIND_LOAD, 6'd63, 6'd63, 32'h8040_2010, 12'd0, 12'd0);
    send_word(KIND_NEAREST, 6'd0, 6'd0, 32'h0, 12'd0, 12'd0);
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'd0, 12'd0);
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'd15, 12'd15);
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'd5, 12'd9);
    send_word(KIND_NEAREST, 6'd0, 6'd0, 32'h0, 12'd15, 12'd0);
    // targets past the canvas still clamp to the source
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'hfff, 12'd3);
    send_word(KIND_NEAREST, 6'd0, 6'd0, 32'h0, 12'd2, 12'hfff);
    // out-of-range size registers clamp
    set_geometry(0, 8191, 0, 8191, 0, 0, 0, 127);
    send_word(KIND_NEAREST, 6'd0, 6'd0, 32'h0, 12'd0, 12'd0);
    send_word(KIND_BILINEAR, 6'd0, 6'd0, 32'h0, 12'd1, 12'd4095);
  endtask

  // region away from the origin, so taps fall outside it too
  task automatic test_offset_region();
    set_geometry(100, 60, 37, 200, 40, 20, 12, 9);
    fill_region();
    no_idle = 1'b1;
    repeat (60) random_sample();
    no_idle = 1'b0;
    repeat (60) random_sample();
  endtask

  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (120) random_sample();
    wait (!hold_req);
  endtask

  task automatic test_random_geometry();
    int unsigned sw, sh, l, t, rw, rh, tw, th;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin sw = 4096; sh = 4096; tw = 1;    th = 1;    end
        1: begin sw = 1;    sh = 1;    tw = 4096; th = 4096; end
        2: begin sw = 4096; sh = 4096; tw = 4096; th = 4096; end
        default: begin
          sw = $urandom_range(1, 300); sh = $urandom_range(1, 300);
          tw = $urandom_range(1, 600); th = $urandom_range(1, 600);
        end
      endcase
      if (p == 6) begin
        rw = 64; rh = 2;
      end else begin
        rw = $urandom_range(1, 10); rh = $urandom_range(1, 10);
      end
      l = (p == 2) ? 4095 : $urandom_range(0, sw - 1);
      t = (p == 2) ? 4095 : $urandom_range(0, sh - 1);
      set_geometry(sw, sh, tw, th, l, t, rw, rh);
      fill_region();
      repeat (30) begin
        // stray loads go to random entries, some outside the region
        if ($urandom_range(0, 9) == 0)
          send_word(KIND_LOAD, 6'($urandom), 6'($urandom), rand_pixel(), 12'd0, 12'd0);
        else if ($urandom_range(0, 49) == 0)
          send_word(KIND_UNUSED, 6'($urandom), 6'($urandom), $urandom,
                    12'($urandom), 12'($urandom));
        else
          random_sample();
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int idle;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        idle = pick_gap();
        if (idle > 0) begin
          out_ready_i <= 1'b0;
          repeat (idle) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // compare each result word, and watch for a hang
  int stall_count = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %08h", $realtime, pixel_out_o);
          mismatches++;
        end else begin
          if (pixel_out_o !== expected_pixels[0]) begin
            $display("%0t: pixel_out expected %08h actual %08h", $realtime,
                     expected_pixels[0], pixel_out_o);
            mismatches++;
          end
          void'(expected_pixels.pop_front());
        end
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("FAIL bilinear_region_resampler_core");
        $finish;
      end
    end
  end

  initial begin
    src_w = 1; src_h = 1; tgt_w = 1; tgt_h = 1;
    rgn_left = 0; rgn_top = 0; rgn_w = 1; rgn_h = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_upscale_corners();
    test_offset_region();
    test_output_stall();
    test_random_geometry();
    end_words();
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS bilinear_region_resampler_core");
    end else begin
      $display("FAIL bilinear_region_resampler_core");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
src/brr_pkg.sv
src/brr_ram.sv
src/brr_div.sv
src/bilinear_region_resampler_core.sv
bench/tb.sv
